### design/pwq_pkg.sv
// Shared types and constants for the propagator wakeup queue.
package pwq_pkg;

    localparam int PROP_W    = 8;
    localparam int VAR_W     = 8;
    localparam int KIND_W    = 2;
    localparam int MASK_W    = 3;
    localparam int CNT_W     = 9;
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 3;
    localparam int ENTRY_W   = PROP_W + MASK_W;
    localparam int LOGE_W    = VAR_W + KIND_W;

    localparam logic [KIND_W-1:0] KIND_INSTANTIATED = 2'd2;

    typedef enum logic [2:0] {
        MODE_ADD_TRIGGER   = 3'd0,
        MODE_BEGIN_FULL    = 3'd1,
        MODE_BEGIN_GUESSED = 3'd2,
        MODE_SEED_GUESS    = 3'd3,
        MODE_INFER         = 3'd4,
        MODE_POP           = 3'd5,
        MODE_DISABLE       = 3'd6,
        MODE_BACKTRACK     = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FIXPOINT = 2'd1,
        ST_FULL     = 2'd2,
        ST_STACK    = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_TRG_WR, S_FILL, S_BEGIN, S_BT_WR,
        S_RET_RD, S_RET_GOT, S_LOC_QO, S_LOC_CHK, S_SW1, S_SW2,
        S_W_CNT, S_W_CNTG, S_TW_RD, S_TW_GOT, S_LOG_RD, S_LOG_GOT,
        S_POP_CHK, S_POP_RD, S_DONE
    } fsm_t;

    typedef struct packed {
        logic [PROP_W-1:0] next_prop;
        logic              prop_valid;
        status_t           status;
    } result_t;

endpackage

### design/pwq_out_stage.sv
// Output register for result transactions; decouples the sequencer from the sink.
module pwq_out_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  pwq_pkg::result_t               res,
    output logic                           can_load,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pwq_pkg::M_TDATA_W-1:0]  m_tdata,   // next_prop
    output logic [pwq_pkg::M_TUSER_W-1:0]  m_tuser    // prop_valid, status[1:0]
);
    import pwq_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg.next_prop;
    assign m_tuser  = {data_reg.status, data_reg.prop_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

endmodule

### design/propagator_wakeup_queue_core.sv
// Propagator wakeup queue: sequencer over the permutation, trigger, log and stack memories.
// A draining pop retires deferred disables, then replays the inference log oldest first and
// walks the triggers of each valid entry; a seed guess walks one variable's triggers. One in flight.
// Reset: async, clears pointers and lengths, then a pass over all MAX_VARIABLES entries zeroes counts.
module propagator_wakeup_queue_core
#(
    parameter int MAX_PROPAGATORS  = 256,
    parameter int MAX_VARIABLES    = 256,
    parameter int TRIGGERS_PER_VAR = 16,
    parameter int LOG_DEPTH        = 256,
    parameter int BACKTRACK_DEPTH  = 64
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pwq_pkg::CNT_W-1:0]      cfg_wdata,  // propagator_count
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // prop_id[7:0], var_index[15:8], event_kind[17:16], trigger_mask[20:18], zero pad
    input  logic [pwq_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [pwq_pkg::S_TUSER_W-1:0]  s_tuser,   // mode[2:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pwq_pkg::M_TDATA_W-1:0]  m_tdata,   // next_prop[7:0]
    output logic [pwq_pkg::M_TUSER_W-1:0]  m_tuser    // prop_valid[0], status[2:1]
);
    import pwq_pkg::*;

    // Widths follow the table sizes.
    localparam int PW  = $clog2(MAX_PROPAGATORS);
    localparam int CW  = $clog2(MAX_PROPAGATORS + 1);
    localparam int VW  = $clog2(MAX_VARIABLES);
    localparam int VCW = $clog2(MAX_VARIABLES + 1);
    localparam int TCW = $clog2(TRIGGERS_PER_VAR + 1);
    localparam int EAW = $clog2(MAX_VARIABLES * TRIGGERS_PER_VAR);
    localparam int LAW = $clog2(LOG_DEPTH);
    localparam int LLW = $clog2(LOG_DEPTH + 1);
    localparam int SAW = $clog2(BACKTRACK_DEPTH);
    localparam int SDW = $clog2(BACKTRACK_DEPTH + 1);
    localparam int IW  = (LLW > CW) ? LLW : CW;

    // Sequencer state
    fsm_t               state_reg, state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CW-1:0]      rb_reg, rb_next, re_reg, re_next, idle_reg, idle_next;
    logic [LLW-1:0]     log_len_reg, log_len_next;
    logic [CW-1:0]      dis_len_reg, dis_len_next;
    logic [SDW-1:0]     sd_reg, sd_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [TCW-1:0]     k_reg, k_next, tcnt_reg, tcnt_next;
    logic [VCW-1:0]     clr_reg, clr_next;
    logic [VAR_W-1:0]   var_reg, var_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [PROP_W-1:0]  pid_reg, pid_next;
    logic [MASK_W-1:0]  mask_reg, mask_next;
    logic [PW-1:0]      p_reg, p_next, q_reg, q_next, tgt_reg, tgt_next, pb_reg, pb_next;
    logic               retire_reg, retire_next;   // swap context: retire vs enqueue
    logic               replay_reg, replay_next;   // wake source: log replay vs seed
    result_t            res_reg, res_next;
    logic               out_load, out_can_load;
    logic [CW-1:0]      n_cur;

    // Memories: one write and one registered read port each
    logic [PW-1:0]      qo_mem [MAX_PROPAGATORS];
    logic [PW-1:0]      qo_raddr, qo_waddr, qo_wdata, qo_rdata;
    logic               qo_we;
    logic [PW-1:0]      po_mem [MAX_PROPAGATORS];
    logic [PW-1:0]      po_raddr, po_waddr, po_wdata, po_rdata;
    logic               po_we;
    logic [TCW-1:0]     tc_mem [MAX_VARIABLES];
    logic [VW-1:0]      tc_raddr, tc_waddr;
    logic [TCW-1:0]     tc_wdata, tc_rdata;
    logic               tc_we;
    logic [ENTRY_W-1:0] te_mem [MAX_VARIABLES * TRIGGERS_PER_VAR];
    logic [EAW-1:0]     te_raddr, te_waddr;
    logic [ENTRY_W-1:0] te_wdata, te_rdata;
    logic               te_we;
    logic [LOGE_W-1:0]  lg_mem [LOG_DEPTH];
    logic [LAW-1:0]     lg_raddr, lg_waddr;
    logic [LOGE_W-1:0]  lg_wdata, lg_rdata;
    logic               lg_we;
    logic [PROP_W-1:0]  ds_mem [MAX_PROPAGATORS];
    logic [PW-1:0]      ds_raddr, ds_waddr;
    logic [PROP_W-1:0]  ds_wdata, ds_rdata;
    logic               ds_we;
    logic [CW-1:0]      sb_mem [BACKTRACK_DEPTH];
    logic [SAW-1:0]     sb_raddr, sb_waddr;
    logic [CW-1:0]      sb_wdata, sb_rdata;
    logic               sb_we;

    logic [MASK_W-1:0]  te_mask;
    logic [VAR_W-1:0]   in_var, lg_var;
    logic [KIND_W-1:0]  lg_kind;
    logic               loc_ok;

    assign n_cur   = (int'(count_reg) < MAX_PROPAGATORS) ? CW'(count_reg)
                                                         : CW'(MAX_PROPAGATORS);
    assign te_mask = te_rdata[ENTRY_W-1:PROP_W];
    assign in_var  = s_tdata[15:8];
    assign lg_var  = lg_rdata[VAR_W-1:0];
    assign lg_kind = lg_rdata[LOGE_W-1:VAR_W];

    always_ff @(posedge clk)
    begin
        if (qo_we) qo_mem[qo_waddr] <= qo_wdata;
        qo_rdata <= qo_mem[qo_raddr];
        if (po_we) po_mem[po_waddr] <= po_wdata;
        po_rdata <= po_mem[po_raddr];
        if (tc_we) tc_mem[tc_waddr] <= tc_wdata;
        tc_rdata <= tc_mem[tc_raddr];
        if (te_we) te_mem[te_waddr] <= te_wdata;
        te_rdata <= te_mem[te_raddr];
        if (lg_we) lg_mem[lg_waddr] <= lg_wdata;
        lg_rdata <= lg_mem[lg_raddr];
        if (ds_we) ds_mem[ds_waddr] <= ds_wdata;
        ds_rdata <= ds_mem[ds_raddr];
        if (sb_we) sb_mem[sb_waddr] <= sb_wdata;
        sb_rdata <= sb_mem[sb_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            count_reg   <= '0;
            rb_reg      <= '0;
            re_reg      <= '0;
            idle_reg    <= '0;
            log_len_reg <= '0;
            dis_len_reg <= '0;
            sd_reg      <= '0;
            clr_reg     <= '0;
            idx_reg     <= '0;
            k_reg       <= '0;
            tcnt_reg    <= '0;
            retire_reg  <= 1'b0;
            replay_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            rb_reg      <= rb_next;
            re_reg      <= re_next;
            idle_reg    <= idle_next;
            log_len_reg <= log_len_next;
            dis_len_reg <= dis_len_next;
            sd_reg      <= sd_next;
            clr_reg     <= clr_next;
            idx_reg     <= idx_next;
            k_reg       <= k_next;
            tcnt_reg    <= tcnt_next;
            retire_reg  <= retire_next;
            replay_reg  <= replay_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        var_reg  <= var_next;
        kind_reg <= kind_next;
        pid_reg  <= pid_next;
        mask_reg <= mask_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        tgt_reg  <= tgt_next;
        pb_reg   <= pb_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        rb_next      = rb_reg;
        re_next      = re_reg;
        idle_next    = idle_reg;
        log_len_next = log_len_reg;
        dis_len_next = dis_len_reg;
        sd_next      = sd_reg;
        clr_next     = clr_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        tcnt_next    = tcnt_reg;
        retire_next  = retire_reg;
        replay_next  = replay_reg;
        var_next     = var_reg;
        kind_next    = kind_reg;
        pid_next     = pid_reg;
        mask_next    = mask_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        tgt_next     = tgt_reg;
        pb_next      = pb_reg;
        res_next     = res_reg;
        s_tready     = 1'b0;
        out_load     = 1'b0;
        loc_ok       = 1'b0;
        qo_raddr = '0; qo_we = 1'b0; qo_waddr = '0; qo_wdata = '0;
        po_raddr = '0; po_we = 1'b0; po_waddr = '0; po_wdata = '0;
        tc_raddr = '0; tc_we = 1'b0; tc_waddr = '0; tc_wdata = '0;
        te_raddr = '0; te_we = 1'b0; te_waddr = '0; te_wdata = '0;
        lg_raddr = '0; lg_we = 1'b0; lg_waddr = '0; lg_wdata = '0;
        ds_raddr = '0; ds_we = 1'b0; ds_waddr = '0; ds_wdata = '0;
        sb_raddr = '0; sb_we = 1'b0; sb_waddr = '0; sb_wdata = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // zero the per-variable trigger counts
                tc_we    = 1'b1;
                tc_waddr = clr_reg[VW-1:0];
                tc_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (int'(clr_reg) == MAX_VARIABLES - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    pid_next  = s_tdata[7:0];
                    var_next  = in_var;
                    kind_next = s_tdata[17:16];
                    mask_next = s_tdata[20:18];
                    res_next  = '{next_prop: '0, prop_valid: 1'b0, status: ST_OK};
                    state_next = S_DONE;
                    unique case (mode_t'(s_tuser[2:0]))
                        MODE_ADD_TRIGGER:
                        begin
                            if (int'(in_var) >= MAX_VARIABLES)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                tc_raddr   = VW'(in_var);
                                state_next = S_TRG_WR;
                            end
                        end
                        MODE_BEGIN_FULL:
                        begin
                            idx_next   = '0;
                            state_next = S_FILL;
                        end
                        MODE_BEGIN_GUESSED:
                        begin
                            rb_next    = '0;
                            re_next    = '0;
                            state_next = S_BEGIN;
                        end
                        MODE_SEED_GUESS:
                        begin
                            kind_next   = KIND_INSTANTIATED;
                            replay_next = 1'b0;
                            if (int'(in_var) < MAX_VARIABLES)
                            begin
                                state_next = S_W_CNT;
                            end
                        end
                        MODE_INFER:
                        begin
                            if (int'(log_len_reg) >= LOG_DEPTH)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                lg_we        = 1'b1;
                                lg_waddr     = log_len_reg[LAW-1:0];
                                lg_wdata     = {s_tdata[17:16], in_var};
                                log_len_next = log_len_reg + 1'b1;
                            end
                        end
                        MODE_POP:
                        begin
                            idx_next = '0;
                            if (rb_reg < re_reg)
                            begin
                                state_next = S_POP_CHK;
                            end
                            else
                            begin
                                state_next = S_RET_RD;
                            end
                        end
                        MODE_DISABLE:
                        begin
                            if (int'(dis_len_reg) >= MAX_PROPAGATORS)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                ds_we        = 1'b1;
                                ds_waddr     = dis_len_reg[PW-1:0];
                                ds_wdata     = s_tdata[7:0];
                                dis_len_next = dis_len_reg + 1'b1;
                            end
                        end
                        MODE_BACKTRACK:
                        begin
                            if (sd_reg == '0)
                            begin
                                res_next.status = ST_STACK;
                            end
                            else
                            begin
                                sb_raddr   = SAW'(sd_reg - 1'b1);
                                sd_next    = sd_reg - 1'b1;
                                state_next = S_BT_WR;
                            end
                        end
                    endcase
                end
            end
            S_TRG_WR:
            begin
                if (int'(tc_rdata) >= TRIGGERS_PER_VAR)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    te_we    = 1'b1;
                    te_waddr = EAW'(int'(var_reg) * TRIGGERS_PER_VAR + int'(tc_rdata));
                    te_wdata = {mask_reg, pid_reg};
                    tc_we    = 1'b1;
                    tc_waddr = VW'(var_reg);
                    tc_wdata = tc_rdata + 1'b1;
                end
                state_next = S_DONE;
            end
            S_FILL:
            begin
                // identity permutation, one entry a cycle
                if (idx_reg < IW'(n_cur))
                begin
                    qo_we    = 1'b1;
                    qo_waddr = idx_reg[PW-1:0];
                    qo_wdata = idx_reg[PW-1:0];
                    po_we    = 1'b1;
                    po_waddr = idx_reg[PW-1:0];
                    po_wdata = idx_reg[PW-1:0];
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    rb_next    = '0;
                    re_next    = n_cur;
                    idle_next  = n_cur;
                    state_next = S_BEGIN;
                end
            end
            S_BEGIN:
            begin
                log_len_next = '0;
                dis_len_next = '0;
                if (int'(sd_reg) >= BACKTRACK_DEPTH)
                begin
                    res_next.status = ST_STACK;
                end
                else
                begin
                    sb_we    = 1'b1;
                    sb_waddr = sd_reg[SAW-1:0];
                    sb_wdata = idle_reg;
                    sd_next  = sd_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_BT_WR:
            begin
                idle_next  = (int'(sb_rdata) > MAX_PROPAGATORS) ? CW'(MAX_PROPAGATORS)
                                                                : sb_rdata;
                state_next = S_DONE;
            end
            S_RET_RD:
            begin
                // retire deferred disables, then reset the ready region
                if (idx_reg < IW'(dis_len_reg))
                begin
                    ds_raddr    = idx_reg[PW-1:0];
                    idx_next    = idx_reg + 1'b1;
                    retire_next = 1'b1;
                    state_next  = S_RET_GOT;
                end
                else
                begin
                    dis_len_next = '0;
                    rb_next      = '0;
                    re_next      = '0;
                    idx_next     = '0;
                    state_next   = S_LOG_RD;
                end
            end
            S_RET_GOT:
            begin
                if (int'(ds_rdata) < MAX_PROPAGATORS)
                begin
                    p_next     = PW'(ds_rdata);
                    po_raddr   = PW'(ds_rdata);
                    state_next = S_LOC_QO;
                end
                else
                begin
                    state_next = S_RET_RD;
                end
            end
            S_LOC_QO:
            begin
                q_next     = po_rdata;
                qo_raddr   = po_rdata;
                state_next = S_LOC_CHK;
            end
            S_LOC_CHK:
            begin
                if (retire_reg)
                begin
                    loc_ok = (qo_rdata == p_reg) && (int'(q_reg) < int'(idle_reg));
                end
                else
                begin
                    loc_ok = (qo_rdata == p_reg) && (int'(q_reg) >= int'(re_reg))
                          && (int'(q_reg) < int'(idle_reg))
                          && (int'(re_reg) < MAX_PROPAGATORS);
                end
                if (loc_ok)
                begin
                    if (retire_reg)
                    begin
                        idle_next = idle_reg - 1'b1;
                        tgt_next  = PW'(idle_reg - 1'b1);
                        qo_raddr  = PW'(idle_reg - 1'b1);
                    end
                    else
                    begin
                        tgt_next = PW'(re_reg);
                        qo_raddr = PW'(re_reg);
                    end
                    state_next = S_SW1;
                end
                else
                begin
                    state_next = retire_reg ? S_RET_RD : S_TW_RD;
                end
            end
            S_SW1:
            begin
                pb_next  = qo_rdata;
                qo_we    = 1'b1;
                qo_waddr = q_reg;
                qo_wdata = qo_rdata;
                po_we    = 1'b1;
                po_waddr = p_reg;
                po_wdata = tgt_reg;
                state_next = S_SW2;
            end
            S_SW2:
            begin
                qo_we    = 1'b1;
                qo_waddr = tgt_reg;
                qo_wdata = p_reg;
                po_we    = 1'b1;
                po_waddr = pb_reg;
                po_wdata = q_reg;
                if (!retire_reg)
                begin
                    re_next = re_reg + 1'b1;
                end
                state_next = retire_reg ? S_RET_RD : S_TW_RD;
            end
            S_W_CNT:
            begin
                tc_raddr   = VW'(var_reg);
                state_next = S_W_CNTG;
            end
            S_W_CNTG:
            begin
                tcnt_next  = tc_rdata;
                k_next     = '0;
                state_next = S_TW_RD;
            end
            S_TW_RD:
            begin
                if (k_reg < tcnt_reg)
                begin
                    te_raddr   = EAW'(int'(var_reg) * TRIGGERS_PER_VAR + int'(k_reg));
                    k_next     = k_reg + 1'b1;
                    state_next = S_TW_GOT;
                end
                else
                begin
                    state_next = replay_reg ? S_LOG_RD : S_DONE;
                end
            end
            S_TW_GOT:
            begin
                if (te_mask[kind_reg] && (int'(te_rdata[PROP_W-1:0]) < MAX_PROPAGATORS))
                begin
                    p_next      = PW'(te_rdata[PROP_W-1:0]);
                    po_raddr    = PW'(te_rdata[PROP_W-1:0]);
                    retire_next = 1'b0;
                    state_next  = S_LOC_QO;
                end
                else
                begin
                    state_next = S_TW_RD;
                end
            end
            S_LOG_RD:
            begin
                // replay logged inferences, oldest first
                if (idx_reg < IW'(log_len_reg))
                begin
                    lg_raddr   = idx_reg[LAW-1:0];
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_LOG_GOT;
                end
                else
                begin
                    log_len_next = '0;
                    state_next   = S_POP_CHK;
                end
            end
            S_LOG_GOT:
            begin
                if ((int'(lg_var) < MAX_VARIABLES) && (lg_kind <= KIND_INSTANTIATED))
                begin
                    var_next    = lg_var;
                    kind_next   = lg_kind;
                    replay_next = 1'b1;
                    state_next  = S_W_CNT;
                end
                else
                begin
                    state_next = S_LOG_RD;
                end
            end
            S_POP_CHK:
            begin
                if ((rb_reg >= re_reg) || (int'(rb_reg) >= MAX_PROPAGATORS))
                begin
                    res_next.status = ST_FIXPOINT;
                    state_next      = S_DONE;
                end
                else
                begin
                    qo_raddr   = rb_reg[PW-1:0];
                    state_next = S_POP_RD;
                end
            end
            S_POP_RD:
            begin
                res_next.next_prop  = PROP_W'(qo_rdata);
                res_next.prop_valid = 1'b1;
                rb_next             = rb_reg + 1'b1;
                state_next          = S_DONE;
            end
            S_DONE:
            begin
                if (out_can_load)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    pwq_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .res      (res_reg),
        .can_load (out_can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Ready region never runs backwards
    a_ready_order: assert property (@(posedge clk) disable iff (!rst_n)
        rb_reg <= re_reg)
        else $error("ready_begin passed ready_end");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(sd_reg) <= BACKTRACK_DEPTH)
        else $error("backtrack stack overflow");

    a_log_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(log_len_reg) <= LOG_DEPTH)
        else $error("log length overflow");

    // A delivered propagator always carries status ok
    a_valid_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == ST_OK)
        else $error("propagator reported with non-ok status");

endmodule

### sim/testbench.sv
// Self-checking testbench for propagator_wakeup_queue_core: directed table plus random phases.
module testbench;
    import pwq_pkg::*;

    localparam int NPROP    = 256;
    localparam int NVAR     = 256;
    localparam int TPV      = 16;
    localparam int LOGD     = 256;
    localparam int STACKD   = 64;
    localparam int WATCHDOG = 200000;
    localparam int NPHASE   = 6;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] pid;
        logic [7:0] vidx;
        logic [1:0] kind;
        logic [2:0] mask;
    } item_t;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t res;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CNT_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    propagator_wakeup_queue_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Scheduler mirror
    int unsigned prop_count;
    logic [7:0]  order_q [NPROP];
    logic [7:0]  slot_of [NPROP];
    int          rdy_lo, rdy_hi, idle_top;
    logic [10:0] trig_tab [NVAR*TPV];
    int          trig_cnt [NVAR];
    logic [9:0]  infer_log [LOGD];
    int          infer_len;
    logic [7:0]  defer_dis [NPROP];
    int          defer_len;
    int          bound_stack [STACKD];
    int          bound_depth;

    result_t     pending_results [$];
    int          errors;
    int          n_props, n_fix, n_full, n_stack;
    int          idle_cyc;
    bit          send_quiet, recv_quiet;

    function automatic bit find_slot(int p, output int q);
        q = 0;
        if (p >= NPROP)
            return 0;
        q = int'(slot_of[p]);
        return order_q[q] == p;
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [7:0] pa;
        logic [7:0] pb;
        pa = order_q[a];
        pb = order_q[b];
        order_q[a] = pb;
        order_q[b] = pa;
        slot_of[pa] = 8'(b);
        slot_of[pb] = 8'(a);
    endfunction

    function automatic void enqueue_idle(int p);
        int q;
        if (!find_slot(p, q))
            return;
        if (q >= rdy_hi && q < idle_top && rdy_hi < NPROP)
        begin
            swap_slots(q, rdy_hi);
            rdy_hi++;
        end
    endfunction

    function automatic void wake_var(int v, int k);
        int c;
        logic [10:0] e;
        if (v >= NVAR || k > 2)
            return;
        c = trig_cnt[v] > TPV ? TPV : trig_cnt[v];
        for (int i = 0; i < c; i++)
        begin
            e = trig_tab[v*TPV + i];
            if (e[8 + k])
                enqueue_idle(int'(e[7:0]));
        end
    endfunction

    function automatic status_t open_pass();
        infer_len = 0;
        defer_len = 0;
        if (bound_depth >= STACKD)
            return ST_STACK;
        bound_stack[bound_depth] = idle_top;
        bound_depth++;
        return ST_OK;
    endfunction

    // Ready region drained: retire deferred disables, then replay the log.
    function automatic void close_round();
        int q;
        for (int i = 0; i < defer_len; i++)
        begin
            if (find_slot(int'(defer_dis[i]), q) && q < idle_top)
            begin
                idle_top--;
                swap_slots(q, idle_top);
            end
        end
        defer_len = 0;
        rdy_lo = 0;
        rdy_hi = 0;
        for (int i = 0; i < infer_len; i++)
            wake_var(int'(infer_log[i][7:0]), int'(infer_log[i][9:8]));
        infer_len = 0;
    endfunction

    function automatic result_t schedule_step(item_t it);
        result_t r;
        int n;
        r = '0;
        r.status = ST_OK;
        n = int'(prop_count < NPROP ? prop_count : NPROP);
        case (it.mode)
            MODE_ADD_TRIGGER:
            begin
                if (trig_cnt[it.vidx] >= TPV)
                    r.status = ST_FULL;
                else
                begin
                    trig_tab[it.vidx*TPV + trig_cnt[it.vidx]] = {it.mask, it.pid};
                    trig_cnt[it.vidx]++;
                end
            end
            MODE_BEGIN_FULL:
            begin
                for (int i = 0; i < n; i++)
                begin
                    order_q[i] = 8'(i);
                    slot_of[i] = 8'(i);
                end
                rdy_lo = 0;
                rdy_hi = n;
                idle_top = n;
                r.status = open_pass();
            end
            MODE_BEGIN_GUESSED:
            begin
                rdy_lo = 0;
                rdy_hi = 0;
                r.status = open_pass();
            end
            MODE_SEED_GUESS:
                wake_var(int'(it.vidx), int'(KIND_INSTANTIATED));
            MODE_INFER:
            begin
                if (infer_len >= LOGD)
                    r.status = ST_FULL;
                else
                begin
                    infer_log[infer_len] = {it.kind, it.vidx};
                    infer_len++;
                end
            end
            MODE_POP:
            begin
                if (rdy_lo >= rdy_hi)
                    close_round();
                if (rdy_lo >= rdy_hi || rdy_lo >= NPROP)
                    r.status = ST_FIXPOINT;
                else
                begin
                    r.next_prop = order_q[rdy_lo];
                    r.prop_valid = 1'b1;
                    rdy_lo++;
                end
            end
            MODE_DISABLE:
            begin
                if (defer_len >= NPROP)
                    r.status = ST_FULL;
                else
                begin
                    defer_dis[defer_len] = it.pid;
                    defer_len++;
                end
            end
            default:
            begin
                if (bound_depth == 0)
                    r.status = ST_STACK;
                else
                begin
                    bound_depth--;
                    idle_top = bound_stack[bound_depth];
                    if (idle_top > NPROP)
                        idle_top = NPROP;
                end
            end
        endcase
        return r;
    endfunction

    function automatic row_t mk_row(mode_t m, int pid, int v, int k, int msk,
                                    bit typed, int nx, bit vl, status_t st);
        row_t r;
        r.it = '{mode: m, pid: 8'(pid), vidx: 8'(v), kind: 2'(k), mask: 3'(msk)};
        r.typed = typed;
        r.res = '{next_prop: 8'(nx), prop_valid: vl, status: st};
        return r;
    endfunction

    // Per-phase mode weights: add, full, guessed, seed, infer, pop, disable, backtrack
    int mode_wt [NPHASE][8] = '{
        '{10, 4, 3, 8, 20, 35, 10, 10},
        '{10, 10, 5, 5, 15, 35, 10, 10},
        '{5, 25, 25, 5, 5, 10, 5, 20},   // pushes more than it pops: stack overflow
        '{10, 0, 0, 0, 25, 0, 65, 0},    // no round boundary: disable list fills
        '{5, 0, 0, 5, 80, 0, 10, 0},     // log fills
        '{8, 5, 5, 10, 20, 35, 10, 7}
    };
    int phase_count [NPHASE] = '{256, 0, 1, 37, 256, 200};
    int phase_items [NPHASE] = '{270, 200, 200, 400, 350, 230};

    function automatic item_t rand_item(int ph);
        item_t it;
        int r, acc, n;
        r = $urandom_range(0, 99);
        acc = 0;
        it.mode = MODE_POP;
        for (int m = 0; m < 8; m++)
        begin
            acc += mode_wt[ph][m];
            if (r < acc)
            begin
                it.mode = mode_t'(m);
                break;
            end
        end
        n = int'(prop_count < NPROP ? prop_count : NPROP);
        if (n > 0 && $urandom_range(0, 9) < 7)
            it.pid = 8'($urandom_range(0, n - 1));
        else
            it.pid = 8'($urandom_range(0, 255));
        // Few variables so trigger lists fill and wakes hit
        if ($urandom_range(0, 9) < 8)
            it.vidx = 8'($urandom_range(0, 3));
        else
            it.vidx = 8'($urandom_range(0, 255));
        it.kind = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        it.mask = 3'($urandom_range(0, 7));
        return it;
    endfunction

    task automatic write_count(int v);
        cfg_we <= 1'b1;
        cfg_wdata <= CNT_W'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        prop_count = unsigned'(v);
    endtask

    // Returns after the transaction is accepted; prediction is queued.
    task automatic send_item(item_t it, bit typed, result_t typed_res);
        int gap;
        result_t r;
        gap = send_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, it.mask, it.kind, it.vidx, it.pid};
        s_tuser <= it.mode;
        do
            @(posedge clk);
        while (!s_tready);
        r = schedule_step(it);
        pending_results = {pending_results, (typed ? typed_res : r)};
    endtask

    task automatic drain_results();
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random stalls, check in order
    initial
    begin
        result_t got, exp_r;
        int stall, taken;
        m_tready <= 1'b0;
        taken = 0;
        recv_quiet = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 50 == 0)
                recv_quiet = ($urandom_range(0, 3) == 0);
            stall = recv_quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            taken++;
            got.next_prop = m_tdata;
            got.prop_valid = m_tuser[0];
            got.status = status_t'(m_tuser[2:1]);
            if (got.prop_valid) n_props++;
            case (got.status)
                ST_FIXPOINT: n_fix++;
                ST_FULL:     n_full++;
                ST_STACK:    n_stack++;
                default: ;
            endcase
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result next_prop=%0d valid=%0d status=%0d",
                         $time, got.next_prop, got.prop_valid, got.status);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got.next_prop !== exp_r.next_prop)
                begin
                    errors++;
                    $display("%0t: next_prop expected %0d actual %0d",
                             $time, exp_r.next_prop, got.next_prop);
                end
                if (got.prop_valid !== exp_r.prop_valid)
                begin
                    errors++;
                    $display("%0t: prop_valid expected %0d actual %0d",
                             $time, exp_r.prop_valid, got.prop_valid);
                end
                if (got.status !== exp_r.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, got.status);
                end
            end
        end
    end

    // Watchdog: consecutive cycles without any transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cyc <= 0;
        else
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cyc <= 0;
            else
                idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= WATCHDOG)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        row_t rows [$];
        item_t it;
        int sent;
        errors = 0;
        n_props = 0; n_fix = 0; n_full = 0; n_stack = 0;
        send_quiet = 0;
        prop_count = 0;
        rdy_lo = 0; rdy_hi = 0; idle_top = 0;
        infer_len = 0; defer_len = 0; bound_depth = 0;
        for (int i = 0; i < NVAR; i++)
            trig_cnt[i] = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // The first full pass with 256 writes every permutation entry, so later
        // wakes and disables never read an unwritten slot.
        write_count(256);

        rows = {rows, mk_row(MODE_BACKTRACK, 0, 0, 0, 0, 1, 0, 0, ST_STACK)};
        rows = {rows, mk_row(MODE_POP, 0, 0, 0, 0, 1, 0, 0, ST_FIXPOINT)};
        rows = {rows, mk_row(MODE_BEGIN_FULL, 0, 0, 0, 0, 1, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_POP, 0, 0, 0, 0, 1, 0, 1, ST_OK)};
        rows = {rows, mk_row(MODE_POP, 0, 0, 0, 0, 1, 1, 1, ST_OK)};
        rows = {rows, mk_row(MODE_ADD_TRIGGER, 255, 255, 0, 7, 1, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_ADD_TRIGGER, 0, 0, 0, 4, 1, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_ADD_TRIGGER, 2, 0, 3, 1, 1, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_INFER, 0, 255, 3, 0, 1, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_INFER, 0, 255, 0, 0, 1, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_DISABLE, 255, 0, 0, 0, 1, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_DISABLE, 255, 0, 0, 0, 1, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_SEED_GUESS, 0, 0, 0, 0, 0, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_POP, 0, 0, 0, 0, 0, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_BEGIN_GUESSED, 0, 0, 0, 0, 1, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_INFER, 0, 0, 0, 0, 0, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_DISABLE, 0, 0, 0, 0, 0, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_POP, 0, 0, 0, 0, 0, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_POP, 0, 0, 0, 0, 0, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_SEED_GUESS, 0, 0, 0, 0, 0, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_BACKTRACK, 0, 0, 0, 0, 0, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_BACKTRACK, 0, 0, 0, 0, 0, 0, 0, ST_OK)};
        rows = {rows, mk_row(MODE_BACKTRACK, 0, 0, 0, 0, 1, 0, 0, ST_STACK)};
        rows = {rows, mk_row(MODE_POP, 0, 0, 0, 0, 0, 0, 0, ST_OK)};

        foreach (rows[i])
            send_item(rows[i].it, rows[i].typed, rows[i].res);

        // Random phases; the count register changes only while the queue is quiet
        sent = 0;
        for (int ph = 0; ph < NPHASE; ph++)
        begin
            s_tvalid <= 1'b0;
            drain_results();
            write_count(phase_count[ph]);
            for (int k = 0; k < phase_items[ph]; k++)
            begin
                if (sent % 64 == 0)
                    send_quiet = ($urandom_range(0, 3) == 0);
                it = rand_item(ph);
                send_item(it, 0, '0);
                sent++;
            end
        end
        s_tvalid <= 1'b0;
        drain_results();

        $display("Ran %0d directed and %0d random transactions over %0d count settings.",
                 rows.size(), sent, NPHASE + 1);
        $display("Results: %0d propagators, %0d fixpoints, %0d full, %0d stack errors.",
                 n_props, n_fix, n_full, n_stack);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
